// ===== rtl/bws_pkg.sv =====
package bws_pkg;

    // input modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic CFG_GATE  = 1'b0;
    localparam logic CFG_START = 1'b1;

    localparam logic [30:0] GATE_RESET  = 31'd13107;
    localparam logic [30:0] START_RESET = 31'd655360000;

    // rotation CORDIC, Q2.30, angle in 2^-20 turn
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [15:0]        heading;
        logic [31:0]        station;
    } t_in;

    typedef struct packed {
        logic [31:0] station_out;
        logic [31:0] width_out;
        logic        matched;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic       q_load;
        logic       cordic_step;
        logic       scan_init;
        logic       rd_en;
        logic       sq_abs;
        logic       sq_mul;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       out_load;
        logic [3:0] step_idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;

    function automatic logic signed [20:0] atan_lut(input logic [3:0] idx);
        logic signed [20:0] v;
        unique case (idx)
            4'd0:  v = 21'sd131072;
            4'd1:  v = 21'sd77376;
            4'd2:  v = 21'sd40884;
            4'd3:  v = 21'sd20753;
            4'd4:  v = 21'sd10417;
            4'd5:  v = 21'sd5213;
            4'd6:  v = 21'sd2607;
            4'd7:  v = 21'sd1304;
            4'd8:  v = 21'sd652;
            4'd9:  v = 21'sd326;
            4'd10: v = 21'sd163;
            4'd11: v = 21'sd81;
            4'd12: v = 21'sd41;
            4'd13: v = 21'sd20;
            4'd14: v = 21'sd10;
            4'd15: v = 21'sd5;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/bws_ram.sv =====
module bws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bws_ctrl.sv =====
module bws_ctrl
    import bws_pkg::*;
#(
    parameter int BORDER_DEPTH = 1024,
    parameter int AW = (BORDER_DEPTH > 1) ? $clog2(BORDER_DEPTH) : 1,
    parameter int CW = $clog2(BORDER_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_mode,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [AW-1:0] o_rd_addr,
    output t_cmd          o_cmd,
    input  t_sts          i_sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_PREP, S_SCAN, S_DRAIN,
        S_SQA, S_SQB, S_SQI, S_SQRT, S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [4:0]    r_step, n_step;
    logic          full;
    logic          in_fire;

    assign full      = (r_count == CW'(BORDER_DEPTH));
    assign in_fire   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_wr_addr = r_count[AW-1:0];
    assign o_rd_addr = r_idx[AW-1:0];

    // sequence loads and clears in idle, and one query: trig, scan, drain, root, result
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_step  = r_step;
        o_wr_en = 1'b0;
        o_cmd   = '0;
        o_cmd.step_idx = r_step[3:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    priority if (i_mode == MODE_LOAD) begin
                        if (!full) begin
                            o_wr_en = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else if (i_mode == MODE_CLEAR) begin
                        n_count = '0;
                    end else if (i_mode == MODE_QUERY) begin
                        o_cmd.q_load = 1'b1;
                        n_step  = '0;
                        n_state = S_CORDIC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 5'(CORDIC_STEPS - 1)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.scan_init = 1'b1;
                n_idx   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_SQA;
                end
            end
            S_SQA: begin
                o_cmd.sq_abs = 1'b1;
                n_state = S_SQB;
            end
            S_SQB: begin
                o_cmd.sq_mul = 1'b1;
                n_state = S_SQI;
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_step  = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 5'd31) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_step  <= n_step;
        end
    end

endmodule

// ===== rtl/bws_dp.sv =====
module bws_dp
    import bws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in         i_in_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    input  logic [63:0] i_rdata,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data
);

    // configuration
    logic [30:0] r_gate, r_start;

    // query operands
    logic signed [31:0] r_px, r_py;
    logic [1:0]         r_quad;
    logic [31:0]        r_station;

    // CORDIC
    logic signed [31:0] r_cx, r_cy;
    logic signed [20:0] r_cz;
    logic signed [31:0] xs, ys;
    logic signed [20:0] at;
    logic signed [32:0] cq, sq;
    logic signed [32:0] cr, sr;
    logic signed [26:0] r_c24, r_s24;

    // scan pipeline
    logic               r_v0, r_v1, r_v2, r_v3, r_v4;
    logic signed [32:0] r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3, r_dx4, r_dy4;
    logic signed [59:0] r_pc, r_ps;
    logic signed [60:0] r_sum;
    logic [60:0]        mag;
    logic [60:0]        rnd;
    logic [36:0]        r_off;
    logic [36:0]        r_best;
    logic               r_found;
    logic signed [32:0] r_bdx, r_bdy;

    // root
    logic [32:0] ax, ay;
    logic        big;
    logic [30:0] r_a, r_b;
    logic        r_half;
    logic [61:0] r_sa, r_sb;
    logic [63:0] r_n;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] rem_sh, trial;
    logic [31:0] width;
    logic        hit;

    logic r_o_valid;
    t_out r_o_data;

    // write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate  <= GATE_RESET;
            r_start <= START_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GATE:  r_gate  <= i_cfg_data;
                CFG_START: r_start <= i_cfg_data;
                default:   r_gate  <= r_gate;
            endcase
        end
    end

    // CORDIC micro-rotation and quadrant fold
    assign xs = r_cx >>> i_cmd.step_idx;
    assign ys = r_cy >>> i_cmd.step_idx;
    assign at = atan_lut(i_cmd.step_idx);

    always_comb begin
        unique case (r_quad)
            2'd0: begin cq = 33'(r_cx);  sq = 33'(r_cy);  end
            2'd1: begin cq = -33'(r_cy); sq = 33'(r_cx);  end
            2'd2: begin cq = -33'(r_cx); sq = -33'(r_cy); end
            default: begin cq = 33'(r_cy); sq = -33'(r_cx); end
        endcase
        cr = cq + 33'sd32;
        sr = sq + 33'sd32;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_px      <= i_in_data.point_x;
            r_py      <= i_in_data.point_y;
            r_quad    <= i_in_data.heading[15:14];
            r_station <= i_in_data.station;
            r_cx      <= CORDIC_GAIN_INV;
            r_cy      <= '0;
            r_cz      <= $signed({3'b000, i_in_data.heading[13:0], 4'b0000});
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[20]) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + at;
            end
        end
        if (i_cmd.scan_init) begin
            r_c24 <= cr[32:6];
            r_s24 <= sr[32:6];
        end
    end

    // scan pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.rd_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign mag = r_sum[60] ? 61'(-r_sum) : 61'(r_sum);
    assign rnd = mag + 61'(1 << 23);

    // difference, products, sum, offset, compare
    always_ff @(posedge i_clk) begin
        r_dx1 <= $signed({i_rdata[63], i_rdata[63:32]}) - $signed({r_px[31], r_px});
        r_dy1 <= $signed({i_rdata[31], i_rdata[31:0]}) - $signed({r_py[31], r_py});
        r_pc  <= r_c24 * r_dx1;
        r_ps  <= r_s24 * r_dy1;
        r_dx2 <= r_dx1;
        r_dy2 <= r_dy1;
        r_sum <= 61'(r_pc) + 61'(r_ps);
        r_dx3 <= r_dx2;
        r_dy3 <= r_dy2;
        r_off <= rnd[60:24];
        r_dx4 <= r_dx3;
        r_dy4 <= r_dy3;
        if (i_cmd.scan_init) begin
            r_best  <= {6'd0, r_start};
            r_found <= 1'b0;
        end else if (r_v4 && (r_off < r_best)) begin
            r_best  <= r_off;
            r_found <= 1'b1;
            r_bdx   <= r_dx4;
            r_bdy   <= r_dy4;
        end
    end

    assign o_sts.pipe_busy = r_v0 | r_v1 | r_v2 | r_v3 | r_v4;

    // operands of the root: halve when either side reaches 2^31
    assign ax  = r_bdx[32] ? 33'(-r_bdx) : 33'(r_bdx);
    assign ay  = r_bdy[32] ? 33'(-r_bdy) : 33'(r_bdy);
    assign big = ax[32] | ax[31] | ay[32] | ay[31];

    assign rem_sh = {r_rem[32:0], r_n[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_abs) begin
            r_half <= big;
            r_a    <= big ? ax[31:1] : ax[30:0];
            r_b    <= big ? ay[31:1] : ay[30:0];
        end
        if (i_cmd.sq_mul) begin
            r_sa <= r_a * r_a;
            r_sb <= r_b * r_b;
        end
        // two bits of the radicand per step
        if (i_cmd.sqrt_init) begin
            r_n    <= 64'(r_sa) + 64'(r_sb);
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_n <= {r_n[61:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign width = r_half ? (r_root[31] ? 32'hFFFF_FFFF : {r_root[30:0], 1'b0}) : r_root;
    assign hit   = r_found && (r_best <= {6'd0, r_gate});

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_data.station_out <= r_station;
            r_o_data.width_out   <= hit ? width : 32'd0;
            r_o_data.matched     <= hit;
        end
    end

    assign o_sts.out_free = !r_o_valid || i_out_ready;
    assign o_out_valid    = r_o_valid;
    assign o_out_data     = r_o_data;

endmodule

// ===== rtl/border_width_search.sv =====
// Channel   Handshake                   Beat
// input     i_in_valid / o_in_ready     t_in: mode, point, heading, station
// output    o_out_valid / i_out_ready   t_out: station_out, width_out, matched
// config    i_cfg_we                    i_cfg_idx, i_cfg_data
//
// Load and clear leave the input ready for the next beat. A query runs
// 16 CORDIC steps, one border store read per stored point through a
// five-stage offset pipeline, an abs and a square state and a 32-step root.
// Synchronous active-low reset empties the store; stored points are
// not cleared. A result waits in the output register; the block takes
// loads and clears meanwhile, and a query holds in its last cycle until
// the output register is free.
module border_width_search
    import bws_pkg::*;
#(
    parameter int BORDER_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    localparam int AW = (BORDER_DEPTH > 1) ? $clog2(BORDER_DEPTH) : 1;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [63:0]   rdata;
    t_cmd          cmd;
    t_sts          sts;

    bws_ctrl #(.BORDER_DEPTH(BORDER_DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_in_data.mode),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bws_ram #(.WIDTH(64), .DEPTH(BORDER_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({i_in_data.point_x, i_in_data.point_y}),
        .i_re    (cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    bws_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_rdata     (rdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/bws_checker.sv =====
module bws_checker
    import bws_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in         i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out        o_out_data,
    input logic        i_cfg_we,
    input logic        i_cfg_idx,
    input logic [30:0] i_cfg_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // a query keeps the input side busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.mode == MODE_QUERY |=> !o_in_ready)
        else $error("input ready right after a query");

    // load and clear produce no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.mode != MODE_QUERY
        |=> !$rose(o_out_valid))
        else $error("result after a non-query beat");

    // unmatched result has zero width
    a_zero_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.matched |-> o_out_data.width_out == 32'd0)
        else $error("unmatched result with nonzero width");

endmodule

bind border_width_search bws_checker u_bws_checker (.*);
